// ===== sv/ultrasonic_obstacle_detector_top_assert.svh =====
`ifndef ULTRASONIC_OBSTACLE_DETECTOR_TOP_ASSERT_SVH
`define ULTRASONIC_OBSTACLE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UOD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/uod_pkg.sv =====
package uod_pkg;

  localparam int PULSE_W = 16;
  localparam int MM_W    = 12;
  localparam int CNT8_W  = 8;
  localparam int SUM_W   = 20;
  localparam int THR_W   = 12;

  // serial divider geometry
  localparam int DVD_W = SUM_W;
  localparam int DEN_W = CNT8_W;
  localparam int STP_W = $clog2(DVD_W + 1);
  localparam logic [STP_W-1:0] DIV_STEPS = STP_W'(DVD_W);

  localparam logic [DEN_W-1:0] MM_DIVISOR = DEN_W'(6);
  localparam logic [DVD_W-1:0] MIN_MM     = DVD_W'(20);
  localparam logic [DVD_W-1:0] MAX_MM     = DVD_W'(4000);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LIM  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(3);

  localparam logic [CNT8_W-1:0]  RST_SAMPLES   = CNT8_W'(10);
  localparam logic [CNT8_W-1:0]  RST_ZERO_LIM  = CNT8_W'(3);
  localparam logic [THR_W-1:0]   RST_THRESHOLD = THR_W'(200);
  localparam logic [PULSE_W-1:0] RST_TIMEOUT   = PULSE_W'(30000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_EVAL,
    ST_AVG,
    ST_EMIT
  } uod_state_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
  } sdiv_sts_t;

endpackage

// ===== sv/uod_sdiv.sv =====
module uod_sdiv import uod_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DEN_W-1:0] den,
  output sdiv_sts_t        sts
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [STP_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, q_r[DVD_W-1]};
    ge       = shifted >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_STEPS;
      q_nxt    = dvd;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      q_nxt   = {q_r[DVD_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(shifted - {1'b0, den_r}) : DEN_W'(shifted);
      cnt_nxt = cnt_r - STP_W'(1);
      if (cnt_r == STP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign sts.done = done_r;
  assign sts.quo  = q_r;

endmodule

// ===== sv/ultrasonic_obstacle_detector_top.sv =====
// channel | ports                                              | direction
// in      | in_valid, in_ready, in_pulse_us                    | item in
// out     | out_valid, out_ready, out_obstacle, out_average_mm,| result out
//         | out_valid_samples, out_ended_early                 |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data          | register write
//
// One shared bit-serial divider: 20 steps for pulse/6, 20 more for the average.
// Item not closing a window: in_ready again after its conversion and evaluation.
// Early end or full window with no valid sample: result after conversion and evaluation.
// Window closing with valid samples: result and in_ready after the average division too.
// Synchronous active-low reset; registers take reset values, window cleared.
// A result waits in the output register; a stalled out side holds the FSM in emit.
module ultrasonic_obstacle_detector_top import uod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PULSE_W-1:0]    in_pulse_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_obstacle,
  output logic [MM_W-1:0]       out_average_mm,
  output logic [CNT8_W-1:0]     out_valid_samples,
  output logic                  out_ended_early,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CNT8_W-1:0]  spw_r, zlim_r;
  logic [THR_W-1:0]   thr_r;
  logic [PULSE_W-1:0] tmo_r;

  uod_state_t         state_r, state_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;
  logic [CNT8_W-1:0]  sidx_r, sidx_nxt;
  logic [CNT8_W-1:0]  zcnt_r, zcnt_nxt;
  logic [CNT8_W-1:0]  vcnt_r, vcnt_nxt;
  logic [SUM_W-1:0]   dsum_r, dsum_nxt;
  logic               res_early_r, res_early_nxt;
  logic [MM_W-1:0]    res_avg_r, res_avg_nxt;
  logic [CNT8_W-1:0]  res_vc_r, res_vc_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_obstacle_r, out_obstacle_nxt;
  logic [MM_W-1:0]    out_avg_r, out_avg_nxt;
  logic [CNT8_W-1:0]  out_vs_r, out_vs_nxt;
  logic               out_early_r, out_early_nxt;

  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DEN_W-1:0]   div_den;
  sdiv_sts_t          div_sts;

  logic               mm_ok;
  logic [CNT8_W-1:0]  limit, window, zc_inc, idx_inc;
  logic [CNT8_W-1:0]  vc_new, zc_new;
  logic [SUM_W-1:0]   sum_new;

  uod_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .den   (div_den),
    .sts   (div_sts)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spw_r  <= RST_SAMPLES;
      zlim_r <= RST_ZERO_LIM;
      thr_r  <= RST_THRESHOLD;
      tmo_r  <= RST_TIMEOUT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLES:   spw_r  <= cfg_data[CNT8_W-1:0];
        REG_ZERO_LIM:  zlim_r <= cfg_data[CNT8_W-1:0];
        REG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        REG_TIMEOUT:   tmo_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mm_ok   = (div_sts.quo >= MIN_MM) && (div_sts.quo <= MAX_MM) && (pulse_r < tmo_r);
    limit   = (zlim_r == '0) ? CNT8_W'(1) : zlim_r;
    window  = (spw_r == '0) ? CNT8_W'(1) : spw_r;
    zc_inc  = zcnt_r + CNT8_W'(1);
    idx_inc = sidx_r + CNT8_W'(1);
    vc_new  = mm_ok ? vcnt_r + CNT8_W'(1) : vcnt_r;
    zc_new  = mm_ok ? zcnt_r : zc_inc;
    sum_new = mm_ok ? dsum_r + {{(SUM_W-MM_W){1'b0}}, div_sts.quo[MM_W-1:0]} : dsum_r;

    div_start = 1'b0;
    div_dvd   = (state_r == ST_IDLE) ? {{(DVD_W-PULSE_W){1'b0}}, in_pulse_us} : sum_new;
    div_den   = (state_r == ST_IDLE) ? MM_DIVISOR : vc_new;

    state_nxt        = state_r;
    pulse_nxt        = pulse_r;
    sidx_nxt         = sidx_r;
    zcnt_nxt         = zcnt_r;
    vcnt_nxt         = vcnt_r;
    dsum_nxt         = dsum_r;
    res_early_nxt    = res_early_r;
    res_avg_nxt      = res_avg_r;
    res_vc_nxt       = res_vc_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_obstacle_nxt = out_obstacle_r;
    out_avg_nxt      = out_avg_r;
    out_vs_nxt       = out_vs_r;
    out_early_nxt    = out_early_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pulse_nxt = in_pulse_us;
          div_start = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (div_sts.done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (!mm_ok && zc_inc >= limit) begin
          // zero limit hit: early end wins
          res_early_nxt = 1'b1;
          res_avg_nxt   = '0;
          res_vc_nxt    = vcnt_r;
          sidx_nxt      = '0;
          zcnt_nxt      = '0;
          vcnt_nxt      = '0;
          dsum_nxt      = '0;
          state_nxt     = ST_EMIT;
        end else if (idx_inc < window) begin
          sidx_nxt  = idx_inc;
          zcnt_nxt  = zc_new;
          vcnt_nxt  = vc_new;
          dsum_nxt  = sum_new;
          state_nxt = ST_IDLE;
        end else begin
          res_early_nxt = 1'b0;
          res_avg_nxt   = '0;
          res_vc_nxt    = vc_new;
          sidx_nxt      = '0;
          zcnt_nxt      = '0;
          vcnt_nxt      = '0;
          dsum_nxt      = '0;
          if (vc_new != '0) begin
            div_start = 1'b1;
            state_nxt = ST_AVG;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_AVG: begin
        if (div_sts.done) begin
          res_avg_nxt = div_sts.quo[MM_W-1:0];
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_obstacle_nxt = !res_early_r && (res_vc_r != '0) && (res_avg_r < thr_r);
          out_avg_nxt      = res_avg_r;
          out_vs_nxt       = res_vc_r;
          out_early_nxt    = res_early_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sidx_r      <= '0;
      zcnt_r      <= '0;
      vcnt_r      <= '0;
      dsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sidx_r      <= sidx_nxt;
      zcnt_r      <= zcnt_nxt;
      vcnt_r      <= vcnt_nxt;
      dsum_r      <= dsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pulse_r        <= pulse_nxt;
    res_early_r    <= res_early_nxt;
    res_avg_r      <= res_avg_nxt;
    res_vc_r       <= res_vc_nxt;
    out_obstacle_r <= out_obstacle_nxt;
    out_avg_r      <= out_avg_nxt;
    out_vs_r       <= out_vs_nxt;
    out_early_r    <= out_early_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_obstacle      = out_obstacle_r;
  assign out_average_mm    = out_avg_r;
  assign out_valid_samples = out_vs_r;
  assign out_ended_early   = out_early_r;

endmodule

// ===== sv/uod_checker.sv =====
`include "ultrasonic_obstacle_detector_top_assert.svh"

module uod_checker import uod_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_obstacle,
  input logic [MM_W-1:0]       out_average_mm,
  input logic [CNT8_W-1:0]     out_valid_samples,
  input logic                  out_ended_early
);

  logic                     in_xfer;
  logic                     out_stall;
  logic [MM_W+CNT8_W+1:0]   out_pl;
  logic                     early_ok;
  logic                     obst_ok;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_pl    = {out_obstacle, out_average_mm, out_valid_samples, out_ended_early};
  assign early_ok  = !out_obstacle && (out_average_mm == '0);
  assign obst_ok   = !out_ended_early && (out_valid_samples != '0) &&
                     (out_average_mm <= MAX_MM[MM_W-1:0]);

  `UOD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_pl), "stalled result changed")

  `UOD_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_ready, "ready right after an input transfer")

  `UOD_ASSERT_NOW(a_early_zero, out_valid && out_ended_early, early_ok, "early end not zeroed")

  `UOD_ASSERT_NOW(a_obst_sane, out_valid && out_obstacle, obst_ok, "obstacle with no average")

endmodule

bind ultrasonic_obstacle_detector_top uod_checker u_uod_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_obstacle      (out_obstacle),
  .out_average_mm    (out_average_mm),
  .out_valid_samples (out_valid_samples),
  .out_ended_early   (out_ended_early)
);

// ===== tb/uod_window_checker.sv =====
`timescale 1ns / 1ps

module uod_window_checker import uod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PULSE_W-1:0]    in_pulse_us,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_obstacle,
  input  logic [MM_W-1:0]       out_average_mm,
  input  logic [CNT8_W-1:0]     out_valid_samples,
  input  logic                  out_ended_early,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           awaiting
);

  typedef struct packed {
    logic              obstacle;
    logic [MM_W-1:0]   average_mm;
    logic [CNT8_W-1:0] valid_samples;
    logic              ended_early;
  } window_verdict_t;

  window_verdict_t verdict_q[$];

  logic [CNT8_W-1:0]  window_len;
  logic [CNT8_W-1:0]  zero_lim;
  logic [THR_W-1:0]   threshold;
  logic [PULSE_W-1:0] timeout;

  logic [CNT8_W-1:0]  sample_idx;
  logic [CNT8_W-1:0]  zero_cnt;
  logic [CNT8_W-1:0]  valid_cnt;
  logic [SUM_W-1:0]   dist_sum;

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  task automatic mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_window();
    sample_idx = '0;
    zero_cnt   = '0;
    valid_cnt  = '0;
    dist_sum   = '0;
  endtask

  task automatic absorb_pulse(input logic [PULSE_W-1:0] pulse);
    logic [PULSE_W-1:0] mm;
    logic               good;
    logic [CNT8_W-1:0]  lim;
    logic [CNT8_W-1:0]  win;
    logic [SUM_W-1:0]   avg;
    window_verdict_t    v;
    mm   = pulse / PULSE_W'(MM_DIVISOR);
    good = !(mm < MIN_MM || mm > MAX_MM || pulse >= timeout);
    lim  = (zero_lim == '0) ? CNT8_W'(1) : zero_lim;
    win  = (window_len == '0) ? CNT8_W'(1) : window_len;
    if (!good) begin
      zero_cnt = zero_cnt + 1'b1;
      if (zero_cnt >= lim) begin
        v.obstacle      = 1'b0;
        v.average_mm    = '0;
        v.valid_samples = valid_cnt;
        v.ended_early   = 1'b1;
        verdict_q.push_back(v);
        clear_window();
        return;
      end
    end else begin
      dist_sum  = dist_sum + SUM_W'(mm);
      valid_cnt = valid_cnt + 1'b1;
    end
    sample_idx = sample_idx + 1'b1;
    if (sample_idx < win) return;
    avg = (valid_cnt != '0) ? dist_sum / SUM_W'(valid_cnt) : '0;
    v.obstacle      = (valid_cnt != '0) && (avg < SUM_W'(threshold));
    v.average_mm    = avg[MM_W-1:0];
    v.valid_samples = valid_cnt;
    v.ended_early   = 1'b0;
    verdict_q.push_back(v);
    clear_window();
  endtask

  always @(posedge clk) begin
    window_verdict_t w;
    if (!rst_n) begin
      window_len = RST_SAMPLES;
      zero_lim   = RST_ZERO_LIM;
      threshold  = RST_THRESHOLD;
      timeout    = RST_TIMEOUT;
      clear_window();
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatch("result transfer with no window pending");
        end else begin
          w = verdict_q.pop_front();
          if (out_obstacle !== w.obstacle)
            mismatch($sformatf("obstacle: got %0d, expected %0d", out_obstacle, w.obstacle));
          if (out_average_mm !== w.average_mm)
            mismatch($sformatf("average_mm: got %0d, expected %0d",
                               out_average_mm, w.average_mm));
          if (out_valid_samples !== w.valid_samples)
            mismatch($sformatf("valid_samples: got %0d, expected %0d",
                               out_valid_samples, w.valid_samples));
          if (out_ended_early !== w.ended_early)
            mismatch($sformatf("ended_early: got %0d, expected %0d",
                               out_ended_early, w.ended_early));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLES:   window_len = cfg_data[CNT8_W-1:0];
          REG_ZERO_LIM:  zero_lim   = cfg_data[CNT8_W-1:0];
          REG_THRESHOLD: threshold  = cfg_data[THR_W-1:0];
          REG_TIMEOUT:   timeout    = cfg_data[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_pulse(in_pulse_us);
    end
    awaiting <= verdict_q.size();
  end

endmodule

// ===== tb/tb_ultrasonic_obstacle_detector_top.sv =====
`timescale 1ns / 1ps

module tb_ultrasonic_obstacle_detector_top;
  import uod_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PULSE_W-1:0]    in_pulse_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_obstacle;
  logic [MM_W-1:0]       out_average_mm;
  logic [CNT8_W-1:0]     out_valid_samples;
  logic                  out_ended_early;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned awaiting;
  bit          steady = 1'b0;
  int          stall_left = 0;
  int          cur_thr = int'(RST_THRESHOLD);
  int          cur_tmo = int'(RST_TIMEOUT);

  ultrasonic_obstacle_detector_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pulse_us       (in_pulse_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_obstacle      (out_obstacle),
    .out_average_mm    (out_average_mm),
    .out_valid_samples (out_valid_samples),
    .out_ended_early   (out_ended_early),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  uod_window_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pulse_us       (in_pulse_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_obstacle      (out_obstacle),
    .out_average_mm    (out_average_mm),
    .out_valid_samples (out_valid_samples),
    .out_ended_early   (out_ended_early),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .awaiting          (awaiting)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** ultrasonic_obstacle_detector_top: FAILED **");
    $finish;
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(40, 150);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 4) == 0) stall_left <= idle_len() + 1;
    end
  end

  function automatic logic [PULSE_W-1:0] pick_pulse();
    int mm;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        mm = cur_thr + $urandom_range(0, 40) - 20;
        if (mm < int'(MIN_MM)) mm = int'(MIN_MM);
        if (mm > int'(MAX_MM)) mm = int'(MAX_MM);
        return PULSE_W'(mm * int'(MM_DIVISOR) + $urandom_range(0, 5));
      end
      3, 4, 5: begin
        mm = $urandom_range(int'(MIN_MM), int'(MAX_MM));
        return PULSE_W'(mm * int'(MM_DIVISOR) + $urandom_range(0, 5));
      end
      6, 7: return PULSE_W'($urandom_range(0, 65535));
      8: begin
        case ($urandom_range(0, 7))
          0: return PULSE_W'(0);
          1: return PULSE_W'(119);
          2: return PULSE_W'(120);
          3: return PULSE_W'(24005);
          4: return PULSE_W'(24006);
          5: return PULSE_W'(65535);
          6: return PULSE_W'(cur_tmo - 1);
          default: return PULSE_W'(cur_tmo);
        endcase
      end
      default: return PULSE_W'($urandom_range(0, 119));
    endcase
  endfunction

  task automatic send_pulse(input logic [PULSE_W-1:0] p);
    int gap;
    in_valid    <= 1'b1;
    in_pulse_us <= p;
    do @(posedge clk); while (!in_ready);
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain results, then cover an item still in flight that closes no window
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input int spw, input int zl, input int thr, input int tmo);
    write_reg(REG_SAMPLES, {8'($urandom), 8'(spw)});
    write_reg(REG_ZERO_LIM, {8'($urandom), 8'(zl)});
    write_reg(REG_THRESHOLD, {4'($urandom), 12'(thr)});
    write_reg(REG_TIMEOUT, 16'(tmo));
    cur_thr = thr;
    cur_tmo = tmo;
  endtask

  initial begin
    int spw;
    int zl;
    int thr;
    int tmo;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: field extremes, range edges, early end on three invalids
    send_pulse(16'd0);
    send_pulse(16'd65535);
    send_pulse(16'd119);
    send_pulse(16'd120);
    send_pulse(16'd24005);
    send_pulse(16'd24006);
    send_pulse(16'd29999);
    send_pulse(16'd600);
    send_pulse(16'd1205);
    settle();

    // timeout edge, full window with no valid sample
    program_regs(2, 3, 4095, 1200);
    send_pulse(16'd0);
    send_pulse(16'd65535);
    send_pulse(16'd1199);
    send_pulse(16'd1200);
    settle();

    // early end and normal end on the same sample
    program_regs(3, 1, 0, 65535);
    send_pulse(16'd600);
    send_pulse(16'd24005);
    send_pulse(16'd0);
    settle();

    // zero window length and zero limit act as one
    program_regs(0, 0, 0, 65535);
    send_pulse(16'd600);
    send_pulse(16'd65535);
    settle();

    // window shortened below samples already taken
    program_regs(10, 255, 200, 30000);
    send_pulse(16'd600);
    send_pulse(16'd1800);
    send_pulse(16'd0);
    send_pulse(16'd1000);
    settle();
    write_reg(8'd4, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    write_reg(REG_SAMPLES, 16'hFF03);
    send_pulse(16'd900);
    settle();

    for (int ph = 0; ph < 31; ph++) begin
      steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0: spw = 0;
        1: spw = 255;
        2: spw = 1;
        default: spw = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 7))
        0: zl = 0;
        1: zl = 255;
        2: zl = 1;
        default: zl = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 7))
        0: thr = 0;
        1: thr = 4095;
        default: thr = $urandom_range(20, 4000);
      endcase
      case ($urandom_range(0, 7))
        0: tmo = 0;
        1: tmo = 65535;
        2: tmo = $urandom_range(120, 24006);
        default: tmo = int'(RST_TIMEOUT);
      endcase
      program_regs(spw, zl, thr, tmo);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
      for (int k = 0; k < 50; k++) begin
        if (k == 25 && $urandom_range(0, 2) == 0) begin
          settle();
          write_reg(REG_SAMPLES, CFG_DATA_W'($urandom_range(1, 12)));
        end
        send_pulse(pick_pulse());
      end
      settle();
    end

    steady = 1'b0;
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("** ultrasonic_obstacle_detector_top: PASSED **");
    end else begin
      $display("** ultrasonic_obstacle_detector_top: FAILED **");
    end
    $finish;
  end

endmodule
